>>> sv/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// shared types and constants for the earliest-deadline-first scheduler
// ----------------------------------------------------------------------------
package edf_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int TIME_W  = 32;
	localparam int WORK_W  = 16;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic              command;
		logic [3:0]        entry_index;
		logic [TIME_W-1:0] arrival_time;
		logic [WORK_W-1:0] burst_length;
		logic [TIME_W-1:0] deadline_time;
	} in_item_t;

	typedef struct packed {
		logic              ran_task;
		logic [3:0]        chosen_index;
		logic              switched;
		logic              finished;
		logic              missed_deadline;
		logic [TIME_W-1:0] current_time;
		logic              all_done;
	} out_item_t;

	typedef struct packed {
		logic              wr_en;
		logic [IDX_W-1:0]  wr_idx;
		logic [TIME_W-1:0] wr_arr;
		logic [TIME_W-1:0] wr_dl;
		logic [WORK_W-1:0] wr_burst;
		logic              dec_en;
		logic [IDX_W-1:0]  dec_idx;
		logic [IDX_W-1:0]  rd_idx;
	} tbl_ctl_t;

endpackage

>>> sv/edf_cmp.sv
// ----------------------------------------------------------------------------
// edf_cmp
// shared unsigned compare unit, two less-than lanes
// ----------------------------------------------------------------------------
module edf_cmp (
	input  logic [edf_pkg::TIME_W-1:0] a0,
	input  logic [edf_pkg::TIME_W-1:0] b0,
	input  logic [edf_pkg::TIME_W-1:0] a1,
	input  logic [edf_pkg::TIME_W-1:0] b1,
	output logic                       lt0,
	output logic                       lt1
);

	assign lt0 = (a0 < b0);
	assign lt1 = (a1 < b1);

endmodule

>>> sv/edf_table.sv
// ----------------------------------------------------------------------------
// edf_table
// task table: arrival and deadline memories, remaining work counters
// ----------------------------------------------------------------------------
module edf_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  edf_pkg::tbl_ctl_t                  ctl,
	output logic [edf_pkg::TIME_W-1:0]         rd_arr,
	output logic [edf_pkg::TIME_W-1:0]         rd_dl,
	output logic [edf_pkg::WORK_W-1:0]         rem_at_dec,
	output logic [edf_pkg::ENTRIES-1:0]        busy
);

	logic [edf_pkg::TIME_W-1:0] arr_mem [edf_pkg::ENTRIES];
	logic [edf_pkg::TIME_W-1:0] dl_mem  [edf_pkg::ENTRIES];
	logic [edf_pkg::WORK_W-1:0] rem_q   [edf_pkg::ENTRIES];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			arr_mem[ctl.wr_idx] <= ctl.wr_arr;
			dl_mem[ctl.wr_idx]  <= ctl.wr_dl;
		end
		rd_arr <= arr_mem[ctl.rd_idx];
		rd_dl  <= dl_mem[ctl.rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < edf_pkg::ENTRIES; i++) begin
				rem_q[i] <= '0;
			end
		end else if (ctl.wr_en) begin
			rem_q[ctl.wr_idx] <= ctl.wr_burst;
		end else if (ctl.dec_en) begin
			rem_q[ctl.dec_idx] <= rem_q[ctl.dec_idx] - edf_pkg::WORK_W'(1);
		end
	end

	assign rem_at_dec = rem_q[ctl.dec_idx];

	always_comb begin
		for (int i = 0; i < edf_pkg::ENTRIES; i++) begin
			busy[i] = |rem_q[i];
		end
	end

endmodule

>>> sv/edf_preemptive_scheduler.sv
// ----------------------------------------------------------------------------
// edf_preemptive_scheduler
// preemptive earliest-deadline-first scheduler with a one-entry-per-cycle scan
// ----------------------------------------------------------------------------
// a load goes from idle to the output state, which fills the output register once the old result is taken
// a tick goes from idle to the scan state, which reads every entry and compares it through
// the shared compare unit, then to one update state and one output state
// one item at a time: in_ready stays low until the item is back in idle, later if a result waits
// reset clears remaining work, time and last run entry; arrival and deadline
// memories hold garbage until loaded and need no clearing pass
// ----------------------------------------------------------------------------
module edf_preemptive_scheduler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  edf_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output edf_pkg::out_item_t out_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]                  state_q;
	logic [edf_pkg::CNT_W-1:0]   cnt_q;
	logic                        issue_s1;
	logic [edf_pkg::IDX_W-1:0]   idx_s1;
	logic                        found_q;
	logic [edf_pkg::IDX_W-1:0]   best_q;
	logic [edf_pkg::TIME_W-1:0]  best_dl_q;
	logic [edf_pkg::TIME_W-1:0]  time_q;
	logic [edf_pkg::IDX_W-1:0]   last_q;
	logic                        last_valid_q;
	logic                        res_ran_q;
	logic [3:0]                  res_idx_q;
	logic                        res_sw_q;
	logic                        res_fin_q;
	logic                        res_miss_q;
	logic                        out_valid_q;
	edf_pkg::out_item_t          out_q;

	edf_pkg::tbl_ctl_t           ctl;
	logic [edf_pkg::TIME_W-1:0]  rd_arr;
	logic [edf_pkg::TIME_W-1:0]  rd_dl;
	logic [edf_pkg::WORK_W-1:0]  rem_at_dec;
	logic [edf_pkg::ENTRIES-1:0] busy;

	logic [edf_pkg::TIME_W-1:0]  cmp_a1;
	logic [edf_pkg::TIME_W-1:0]  cmp_b1;
	logic                        lt0;
	logic                        lt1;
	logic                        in_xfer;
	logic                        out_xfer;
	logic                        scan_end;
	logic                        eligible;
	logic [edf_pkg::TIME_W-1:0]  time_next;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_xfer  = out_valid_q && out_ready;
	assign out_data  = out_q;

	assign scan_end  = (cnt_q == edf_pkg::CNT_W'(edf_pkg::ENTRIES)) && !issue_s1;
	assign time_next = (time_q == edf_pkg::TIME_MAX) ? time_q
		: time_q + edf_pkg::TIME_W'(1);

	// lane 1: deadline vs best during scan, deadline vs completion time on update
	assign cmp_a1 = (state_q == S_UPD) ? best_dl_q : rd_dl;
	assign cmp_b1 = (state_q == S_UPD) ? time_next : best_dl_q;

	edf_cmp u_cmp (
		.a0  (time_q),
		.b0  (rd_arr),
		.a1  (cmp_a1),
		.b1  (cmp_b1),
		.lt0 (lt0),
		.lt1 (lt1)
	);

	assign eligible = issue_s1 && busy[idx_s1] && !lt0;

	always_comb begin
		ctl          = '0;
		ctl.wr_en    = in_xfer && (in_data.command == edf_pkg::CMD_LOAD)
			&& (32'(in_data.entry_index) < edf_pkg::ENTRIES);
		ctl.wr_idx   = edf_pkg::IDX_W'(in_data.entry_index);
		ctl.wr_arr   = in_data.arrival_time;
		ctl.wr_dl    = in_data.deadline_time;
		ctl.wr_burst = in_data.burst_length;
		ctl.dec_en   = (state_q == S_UPD) && found_q;
		ctl.dec_idx  = best_q;
		ctl.rd_idx   = cnt_q[edf_pkg::IDX_W-1:0];
	end

	edf_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rd_arr     (rd_arr),
		.rd_dl      (rd_dl),
		.rem_at_dec (rem_at_dec),
		.busy       (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			issue_s1     <= 1'b0;
			found_q      <= 1'b0;
			time_q       <= '0;
			last_q       <= '0;
			last_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			issue_s1 <= (state_q == S_SCAN)
				&& (cnt_q < edf_pkg::CNT_W'(edf_pkg::ENTRIES));
			if (out_xfer && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						if (in_data.command == edf_pkg::CMD_TICK) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SCAN: begin
					if (cnt_q < edf_pkg::CNT_W'(edf_pkg::ENTRIES)) begin
						cnt_q <= cnt_q + edf_pkg::CNT_W'(1);
					end
					if (eligible && (!found_q || lt1)) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					time_q <= time_next;
					if (found_q) begin
						last_q       <= best_q;
						last_valid_q <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && eligible && (!found_q || lt1)) begin
			best_q    <= idx_s1;
			best_dl_q <= rd_dl;
		end
		idx_s1 <= cnt_q[edf_pkg::IDX_W-1:0];
		if (in_xfer) begin
			res_ran_q  <= 1'b0;
			res_idx_q  <= '0;
			res_sw_q   <= 1'b0;
			res_fin_q  <= 1'b0;
			res_miss_q <= 1'b0;
		end
		if (state_q == S_UPD && found_q) begin
			res_ran_q  <= 1'b1;
			res_idx_q  <= 4'(best_q);
			res_sw_q   <= !last_valid_q || (last_q != best_q);
			res_fin_q  <= (rem_at_dec == edf_pkg::WORK_W'(1));
			res_miss_q <= (rem_at_dec == edf_pkg::WORK_W'(1)) && lt1;
		end
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_q.ran_task        <= res_ran_q;
			out_q.chosen_index    <= res_idx_q;
			out_q.switched        <= res_sw_q;
			out_q.finished        <= res_fin_q;
			out_q.missed_deadline <= res_miss_q;
			out_q.current_time    <= time_q;
			out_q.all_done        <= ~|busy;
		end
	end

	a_tick_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_data.command == edf_pkg::CMD_TICK) |=> state_q == S_SCAN)
		else $error("tick transfer did not start a scan");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> cnt_q <= edf_pkg::CNT_W'(edf_pkg::ENTRIES))
		else $error("scan counter past table end");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.ran_task) |->
		(out_q.chosen_index == 4'd0 && !out_q.switched && !out_q.finished))
		else $error("idle result carries task flags");

	a_miss_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.missed_deadline) |-> (out_q.finished && out_q.ran_task))
		else $error("deadline miss without completion");

	a_dec_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.dec_en |-> busy[ctl.dec_idx])
		else $error("work spent on an empty entry");

endmodule
